@@ hw/rtl/ms_pkg.sv @@
// Merge sorter package: default sizes and the control/status bundles
// passed between the sequencer and the datapath. No dependencies.
`default_nettype none

package ms_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int DATA_WIDTH_DEF   = 32;

	typedef struct packed {
		logic load;
		logic sort_start;
		logic run_setup;
		logic merge_step;
		logic pass_end;
		logic emit_en;
		logic set_clear;
	} ms_cmd_t;

	typedef struct packed {
		logic sort_needed;
		logic run_done;
		logic pass_done;
		logic emit_done;
	} ms_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/ms_if.sv @@
// Valid/ready channels of the merge sorter: input elements and sorted results.
// Depends on ms_pkg for default widths.
`default_nettype none

interface ms_item_if import ms_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value_in;
	logic                         last_in;

	modport source (output valid, output value_in, output last_in, input ready);
	modport sink   (input valid, input value_in, input last_in, output ready);
endinterface

interface ms_result_if import ms_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value_out;
	logic                         last_out;
	logic                         overflow;

	modport source (output valid, output value_out, output last_out, output overflow,
		input ready);
	modport sink   (input valid, input value_out, input last_out, input overflow,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/merge_sorter.sv @@
// Merge sorter: loads one element per cycle, sorts n kept elements bottom-up,
// then streams them out one per cycle while results.ready is held. Sorting
// gives one merged element per cycle on the buffer read ports, with an S_SETUP
// step per run and an S_CHECK step per pass; each result passes the read
// register and then the output register. Async active-low reset clears
// control; buffers are not cleared.
`default_nettype none

module merge_sorter import ms_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	ms_item_if.sink     items,
	ms_result_if.source results
);

	ms_cmd_t    cmd;
	ms_status_t status;

	ms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_last  (items.last_in),
		.in_ready (items.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ms_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.DATA_WIDTH   (DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value_in  (items.value_in),
		.cmd       (cmd),
		.status    (status),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.value_out (results.value_out),
		.last_out  (results.last_out),
		.overflow  (results.overflow)
	);

	// loading resumes only after a set has been fully handed to the output stage
	a_load_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(items.ready) |-> $past(cmd.set_clear))
		else $error("load resumed without set clear");

	a_no_merge_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_step |-> !items.ready)
		else $error("merge step while accepting requests");

	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && !results.last_out |=>
		(!results.valid || (results.overflow == $past(results.overflow))))
		else $error("overflow flag changed within a set");

endmodule

`default_nettype wire

@@ hw/rtl/ms_ctrl.sv @@
// Merge sorter sequencer: load, per-run setup, merge passes, emission.
// Depends on ms_pkg for the command and status bundles.
`default_nettype none

module ms_ctrl import ms_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_last,
	output logic            in_ready,
	input  wire ms_status_t status,
	output ms_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_SETUP,
		S_MERGE,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && in_last) begin
					cmd.sort_start = 1'b1;
					state_d        = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = status.sort_needed ? S_SETUP : S_EMIT;
			end
			S_SETUP: begin
				cmd.run_setup = 1'b1;
				state_d       = S_MERGE;
			end
			S_MERGE: begin
				cmd.merge_step = 1'b1;
				if (status.run_done) begin
					if (status.pass_done) begin
						cmd.pass_end = 1'b1;
						state_d      = S_CHECK;
					end else begin
						state_d = S_SETUP;
					end
				end
			end
			S_EMIT: begin
				cmd.emit_en = 1'b1;
				if (status.emit_done) begin
					cmd.set_clear = 1'b1;
					state_d       = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ms_datapath.sv @@
// Merge sorter datapath: ping-pong element buffers, run counters, compare
// and select, emission pipeline. Depends on ms_pkg; driven by ms_ctrl.
`default_nettype none

module ms_datapath import ms_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_wdata,
	input  wire logic signed [DATA_WIDTH-1:0] value_in,
	input  wire ms_cmd_t                      cmd,
	output ms_status_t                        status,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic signed [DATA_WIDTH-1:0]      value_out,
	output logic                              last_out,
	output logic                              overflow
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int SW = CW + 3;

	logic signed [DATA_WIDTH-1:0] mem_a [MAX_ELEMENTS];
	logic signed [DATA_WIDTH-1:0] mem_b [MAX_ELEMENTS];

	logic                         sort_descending_q;
	logic [CW-1:0]                count_q;
	logic                         dropped_q;
	logic [CW:0]                  width_q;
	logic                         src_sel_q;
	logic [CW-1:0]                k_q, i_q, j_q, mid_q, hi_q;
	logic signed [DATA_WIDTH-1:0] rd_l_q, rd_r_q;
	logic                         pre_v_q, pre_last_q, pre_ovf_q;
	logic                         out_v_q, out_last_q, out_ovf_q;
	logic signed [DATA_WIDTH-1:0] out_value_q;

	logic                         full;
	logic [SW-1:0]                mid_sum, hi_sum, n_ext;
	logic [CW-1:0]                mid_d, hi_d, i_nx, j_nx, k_inc;
	logic                         left_ok, right_ok, l_first, take_l;
	logic signed [DATA_WIDTH-1:0] merge_data;
	logic                         out_adv, emit_issue, rd_en;
	logic [CW-1:0]                addr_l, addr_r;

	always_comb begin
		full     = (count_q == CW'(MAX_ELEMENTS));
		n_ext    = SW'(count_q);
		mid_sum  = SW'(k_q) + SW'(width_q);
		hi_sum   = SW'(k_q) + (SW'(width_q) << 1);
		mid_d    = (mid_sum > n_ext) ? count_q : mid_sum[CW-1:0];
		hi_d     = (hi_sum > n_ext) ? count_q : hi_sum[CW-1:0];
		left_ok  = (i_q < mid_q);
		right_ok = (j_q < hi_q);
		l_first  = sort_descending_q ? (rd_r_q < rd_l_q) : (rd_l_q < rd_r_q);
		// equal keys: right run first
		take_l     = left_ok && (!right_ok || l_first);
		merge_data = take_l ? rd_l_q : rd_r_q;
		i_nx       = i_q + {{(CW-1){1'b0}}, take_l};
		j_nx       = j_q + {{(CW-1){1'b0}}, !take_l};
		k_inc      = k_q + CW'(1);
		out_adv    = !out_v_q || out_ready;
		emit_issue = cmd.emit_en && (k_q != count_q) && (!pre_v_q || out_adv);
	end

	always_comb begin
		rd_en  = 1'b0;
		addr_l = k_q;
		addr_r = k_q;
		priority if (cmd.run_setup) begin
			rd_en  = 1'b1;
			addr_l = k_q;
			addr_r = mid_d;
		end else if (cmd.merge_step) begin
			rd_en  = 1'b1;
			addr_l = i_nx;
			addr_r = j_nx;
		end else if (emit_issue) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		status.sort_needed = ((CW+1)'(count_q) > width_q);
		status.run_done    = (k_inc == hi_q);
		status.pass_done   = (hi_q == count_q);
		status.emit_done   = (k_q == count_q) && !pre_v_q;
	end

	// buffer a: loaded with input, merge target on even passes (the first pass writes b)
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem_a[count_q[AW-1:0]] <= value_in;
		end else if (cmd.merge_step && src_sel_q) begin
			mem_a[k_q[AW-1:0]] <= merge_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.merge_step && !src_sel_q) begin
			mem_b[k_q[AW-1:0]] <= merge_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_l_q <= src_sel_q ? mem_b[addr_l[AW-1:0]] : mem_a[addr_l[AW-1:0]];
			rd_r_q <= src_sel_q ? mem_b[addr_r[AW-1:0]] : mem_a[addr_r[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_descending_q <= 1'b0;
			count_q           <= '0;
			dropped_q         <= 1'b0;
			width_q           <= '0;
			src_sel_q         <= 1'b0;
			k_q               <= '0;
			i_q               <= '0;
			j_q               <= '0;
			mid_q             <= '0;
			hi_q              <= '0;
			pre_v_q           <= 1'b0;
			out_v_q           <= 1'b0;
		end else begin
			if (cfg_we) begin
				sort_descending_q <= cfg_wdata;
			end

			if (cmd.set_clear) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else if (cmd.load) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end

			if (cmd.sort_start) begin
				width_q   <= (CW+1)'(1);
				src_sel_q <= 1'b0;
			end else if (cmd.pass_end) begin
				width_q   <= width_q << 1;
				src_sel_q <= !src_sel_q;
			end

			if (cmd.set_clear || cmd.sort_start || cmd.pass_end) begin
				k_q <= '0;
			end else if (cmd.merge_step || emit_issue) begin
				k_q <= k_inc;
			end

			if (cmd.run_setup) begin
				i_q   <= k_q;
				j_q   <= mid_d;
				mid_q <= mid_d;
				hi_q  <= hi_d;
			end else if (cmd.merge_step) begin
				i_q <= i_nx;
				j_q <= j_nx;
			end

			if (emit_issue) begin
				pre_v_q <= 1'b1;
			end else if (out_adv) begin
				pre_v_q <= 1'b0;
			end

			if (out_adv) begin
				out_v_q <= pre_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_issue) begin
			pre_last_q <= (k_inc == count_q);
			pre_ovf_q  <= dropped_q;
		end
		if (out_adv) begin
			out_value_q <= rd_l_q;
			out_last_q  <= pre_last_q;
			out_ovf_q   <= pre_ovf_q;
		end
	end

	assign out_valid = out_v_q;
	assign value_out = out_value_q;
	assign last_out  = out_last_q;
	assign overflow  = out_ovf_q;

endmodule

`default_nettype wire
